### src/capacitive_touch_detector_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the capacitive touch detector
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// -----------------------------------------------------------------------------
`ifndef CAPACITIVE_TOUCH_DETECTOR_MACROS_SVH
`define CAPACITIVE_TOUCH_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ctd_pkg.sv
// -----------------------------------------------------------------------------
// Capacitive touch detector package
// Widths, reset values, register indexes, beat types and the threshold
// calibration helper shared by all detector modules.
// -----------------------------------------------------------------------------
package ctd_pkg;

  localparam int LevelW   = 10;
  localparam int ThrW     = 10;
  localparam int BaseW    = 15;
  localparam int CntW     = 16;
  localparam int HoldW    = 5;
  localparam int AvgShift = 5;
  localparam int CfgW     = 16;
  localparam int MeanW    = BaseW - AvgShift;

  localparam logic [HoldW-1:0] HoldLimit     = 5'd20;
  localparam logic [ThrW-1:0]  ThrDefaultRst = 10'd100;
  localparam logic [ThrW-1:0]  ThrMinRst     = 10'd20;
  localparam logic [ThrW-1:0]  ThrMaxRst     = 10'd400;
  localparam logic [CntW-1:0]  StuckLimitRst = 16'd160;

  typedef enum logic [1:0] {
    CFG_THR_DEFAULT = 2'd0,
    CFG_THR_MIN     = 2'd1,
    CFG_THR_MAX     = 2'd2,
    CFG_STUCK_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] level_first;
    logic [LevelW-1:0] level_second;
  } in_item_t;

  typedef struct packed {
    logic pressed_first;
    logic pressed_second;
    logic calibrating;
    logic abort_setup;
  } out_item_t;

  // Per-key detection status for the current scan.
  typedef struct packed {
    logic pressed;
    logic stuck;
  } key_stat_t;

  // Calibration sequencer controls for the current scan.
  typedef struct packed {
    logic            set_thr;
    logic [ThrW-1:0] thr_first;
    logic [ThrW-1:0] thr_second;
    logic            abort;
    logic            preload;
    logic            indicator;
  } cal_ctl_t;

  // Half the swing between release and press, raised to the minimum first and
  // then lowered to the maximum, so the maximum wins when the limits cross.
  function automatic logic [ThrW-1:0] cal_threshold(
    input logic [LevelW-1:0] rel,
    input logic [LevelW-1:0] prs,
    input logic [ThrW-1:0]   tmin,
    input logic [ThrW-1:0]   tmax
  );
    logic [LevelW-1:0] swing;
    logic [ThrW-1:0]   t;
    swing = rel - prs;
    if (rel < prs) begin
      t = tmax;
    end else begin
      t = ThrW'(swing >> 1);
    end
    if (t < tmin) begin
      t = tmin;
    end
    if (t > tmax) begin
      t = tmax;
    end
    return t;
  endfunction

endpackage

### src/capacitive_touch_detector.sv
// -----------------------------------------------------------------------------
// Capacitive touch detector
// Two-key baseline tracking touch detector with stuck-key recovery and
// two-key threshold calibration.
// -----------------------------------------------------------------------------
// Usage: every input beat on in_data_i is one completed scan of both touch
// sensors, and every scan yields exactly one output beat on out_data_o with the
// two key states, the calibration indicator and the setup-abort flag.
// Both channels use valid/stall: a beat moves at a rising edge where valid is
// high and stall is low.
// A scan is registered in the input register at the accepting edge, evaluated
// in a single pass of logic against the key state, and its result is registered
// in the result register once that register is free or draining.
// The block takes one scan per cycle while the receiver does not stall; the
// only loop is the key and calibration state, which updates in the same cycle
// as the result.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more scan, after which in_stall_o rises.
// Reset loads the default thresholds and limits, clears all counters and arms
// a baseline preload, so the first scan after reset reports both keys released.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
// block is idle; writing the default threshold also loads both key thresholds.
// -----------------------------------------------------------------------------
`include "capacitive_touch_detector_macros.svh"

module capacitive_touch_detector import ctd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  // Configuration registers.
  logic [ThrW-1:0] thr_min_q;
  logic [ThrW-1:0] thr_max_q;
  logic [CntW-1:0] stuck_limit_q;
  logic            thr_load;

  // Input and result registers.
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t res;

  // The held scan is evaluated when the result register is free or draining.
  logic advance;
  logic need_preload_q;

  key_stat_t stat_first, stat_second;
  cal_ctl_t  cal;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign thr_load   = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_THR_DEFAULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_min_q     <= ThrMinRst;
      thr_max_q     <= ThrMaxRst;
      stuck_limit_q <= StuckLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THR_DEFAULT: begin
          // The default threshold goes straight into both key thresholds.
        end
        CFG_THR_MIN:     thr_min_q     <= cfg_wdata_i[ThrW-1:0];
        CFG_THR_MAX:     thr_max_q     <= cfg_wdata_i[ThrW-1:0];
        CFG_STUCK_LIMIT: stuck_limit_q <= cfg_wdata_i[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  ctd_key u_key_first (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .preload_i     (need_preload_q),
    .level_i       (in_q.level_first),
    .thr_load_i    (thr_load),
    .thr_default_i (cfg_wdata_i[ThrW-1:0]),
    .cal_set_i     (cal.set_thr),
    .cal_thr_i     (cal.thr_first),
    .stuck_limit_i (stuck_limit_q),
    .stat_o        (stat_first)
  );

  ctd_key u_key_second (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .preload_i     (need_preload_q),
    .level_i       (in_q.level_second),
    .thr_load_i    (thr_load),
    .thr_default_i (cfg_wdata_i[ThrW-1:0]),
    .cal_set_i     (cal.set_thr),
    .cal_thr_i     (cal.thr_second),
    .stuck_limit_i (stuck_limit_q),
    .stat_o        (stat_second)
  );

  ctd_cal u_cal (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .key_first_i    (stat_first.pressed),
    .key_second_i   (stat_second.pressed),
    .level_first_i  (in_q.level_first),
    .level_second_i (in_q.level_second),
    .thr_min_i      (thr_min_q),
    .thr_max_i      (thr_max_q),
    .ctl_o          (cal)
  );

  always_comb begin
    res.pressed_first  = stat_first.pressed;
    res.pressed_second = stat_second.pressed;
    res.calibrating    = cal.indicator;
    res.abort_setup    = stat_first.stuck || stat_second.stuck || cal.abort;
  end

  // A stuck key, an aborted hold or a finished calibration arms a preload of
  // both baselines on the next scan; a scan with none of these disarms it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_preload_q <= 1'b1;
    end else if (advance) begin
      need_preload_q <= stat_first.stuck || stat_second.stuck || cal.preload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CTD_ASSERT_SAME(a_preload_releases, advance && need_preload_q,
    !res.pressed_first && !res.pressed_second, "preload scan reported a press")
  `CTD_ASSERT_NEXT(a_abort_arms_preload, advance && res.abort_setup,
    need_preload_q, "setup abort did not arm a baseline preload")
  `CTD_ASSERT_NEXT(a_scan_held_on_stall, in_valid_q && !advance,
    in_valid_q && $stable(in_q), "held scan lost while result register was busy")

endmodule

### src/ctd_key.sv
// -----------------------------------------------------------------------------
// Touch key channel
// Baseline tracking, threshold compare and stuck-key counter for one sensor.
// -----------------------------------------------------------------------------
module ctd_key import ctd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              preload_i,
  input  logic [LevelW-1:0] level_i,
  input  logic              thr_load_i,
  input  logic [ThrW-1:0]   thr_default_i,
  input  logic              cal_set_i,
  input  logic [ThrW-1:0]   cal_thr_i,
  input  logic [CntW-1:0]   stuck_limit_i,
  output key_stat_t         stat_o
);

  logic [BaseW-1:0] baseline_q, baseline_d;
  logic [ThrW-1:0]  thr_q, thr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [MeanW-1:0]  mean;
  logic signed [11:0] diff;
  logic               above;
  logic               pressed;

  always_comb begin
    mean    = baseline_q[BaseW-1:AvgShift];
    // Signed difference so a threshold above the mean never wraps to a press.
    diff    = $signed({2'b00, mean}) - $signed({2'b00, thr_q});
    above   = diff > $signed({2'b00, level_i});
    pressed = !preload_i && above;

    if (preload_i) begin
      baseline_d = {level_i, {AvgShift{1'b0}}};
    end else if (pressed) begin
      baseline_d = baseline_q;
    end else begin
      baseline_d = baseline_q - {{AvgShift{1'b0}}, mean} + {{AvgShift{1'b0}}, level_i};
    end

    if (pressed) begin
      cnt_d = (cnt_q == {CntW{1'b1}}) ? cnt_q : cnt_q + 1'b1;
    end else begin
      cnt_d = '0;
    end

    if (thr_load_i) begin
      thr_d = thr_default_i;
    end else if (step_i && cal_set_i) begin
      thr_d = cal_thr_i;
    end else begin
      thr_d = thr_q;
    end

    stat_o.pressed = pressed;
    stat_o.stuck   = pressed && (cnt_d >= stuck_limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      thr_q      <= ThrDefaultRst;
      cnt_q      <= '0;
    end else begin
      thr_q <= thr_d;
      if (step_i) begin
        baseline_q <= baseline_d;
        cnt_q      <= cnt_d;
      end
    end
  end

endmodule

### src/ctd_cal.sv
// -----------------------------------------------------------------------------
// Calibration sequencer
// Two-key hold sequence that captures press levels and derives new thresholds.
// -----------------------------------------------------------------------------
module ctd_cal import ctd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              key_first_i,
  input  logic              key_second_i,
  input  logic [LevelW-1:0] level_first_i,
  input  logic [LevelW-1:0] level_second_i,
  input  logic [ThrW-1:0]   thr_min_i,
  input  logic [ThrW-1:0]   thr_max_i,
  output cal_ctl_t          ctl_o
);

  typedef enum logic [3:0] {
    CAL_IDLE    = 4'b0001,
    CAL_CONFIRM = 4'b0010,
    CAL_TIMING  = 4'b0100,
    CAL_DONE    = 4'b1000
  } cal_state_e;

  cal_state_e        state_q, state_d;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [LevelW-1:0] press_first_q, press_first_d;
  logic [LevelW-1:0] press_second_q, press_second_d;
  logic              ind_q, ind_d;
  logic              both, none;

  always_comb begin
    both           = key_first_i && key_second_i;
    none           = !key_first_i && !key_second_i;
    state_d        = state_q;
    hold_d         = hold_q;
    press_first_d  = press_first_q;
    press_second_d = press_second_q;
    ind_d          = ind_q;
    ctl_o.set_thr  = 1'b0;
    ctl_o.abort    = 1'b0;
    ctl_o.preload  = 1'b0;
    ctl_o.thr_first  = cal_threshold(level_first_i, press_first_q, thr_min_i, thr_max_i);
    ctl_o.thr_second = cal_threshold(level_second_i, press_second_q, thr_min_i, thr_max_i);

    case (state_q)
      CAL_IDLE: begin
        if (both) begin
          state_d = CAL_CONFIRM;
        end
      end
      CAL_CONFIRM: begin
        if (both) begin
          press_first_d  = level_first_i;
          press_second_d = level_second_i;
          hold_d         = '0;
          state_d        = CAL_TIMING;
        end else begin
          state_d = CAL_IDLE;
        end
      end
      CAL_TIMING: begin
        ind_d = 1'b1;
        if (both) begin
          hold_d = hold_q + 1'b1;
          if (hold_d > HoldLimit) begin
            ctl_o.abort   = 1'b1;
            ctl_o.preload = 1'b1;
            state_d       = CAL_DONE;
          end
        end else if (none) begin
          ctl_o.set_thr = 1'b1;
          ctl_o.preload = 1'b1;
          state_d       = CAL_DONE;
        end
      end
      default: begin
        state_d = CAL_IDLE;
        ind_d   = 1'b0;
      end
    endcase

    ctl_o.indicator = ind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CAL_IDLE;
      hold_q  <= '0;
      ind_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      hold_q  <= hold_d;
      ind_q   <= ind_d;
    end
  end

  // Press levels are always captured before the timing phase reads them.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      press_first_q  <= press_first_d;
      press_second_q <= press_second_d;
    end
  end

endmodule

### dv/touch_result_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Touch result checker
// Watches the scan, result and register ports of the detector, predicts the
// result of every accepted scan, and compares each result beat with the oldest
// predicted one, field by field.
// -----------------------------------------------------------------------------
module touch_result_checker import ctd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_item_t        in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_item_t       out_data_i,
  output int              outstanding_o,
  output int              mismatches_o
);

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_CONFIRM,
    CAL_TIMING,
    CAL_DONE
  } cal_phase_e;

  logic [ThrW-1:0]   thr_min_q;
  logic [ThrW-1:0]   thr_max_q;
  logic [CntW-1:0]   stuck_limit_q;

  logic [BaseW-1:0]  base_q  [2];
  logic [ThrW-1:0]   thr_q   [2];
  logic [CntW-1:0]   stuck_q [2];
  logic [LevelW-1:0] press_q [2];
  logic              preload_q;
  cal_phase_e        phase_q;
  logic [HoldW-1:0]  hold_q;
  logic              ind_q;

  out_item_t         expected_reports_q [$];
  out_item_t         predicted;
  out_item_t         oldest;
  int                mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
    end
  endtask

  task automatic reset_model();
    thr_min_q     = ThrMinRst;
    thr_max_q     = ThrMaxRst;
    stuck_limit_q = StuckLimitRst;
    for (int k = 0; k < 2; k++) begin
      base_q[k]  = '0;
      thr_q[k]   = ThrDefaultRst;
      stuck_q[k] = '0;
      press_q[k] = '0;
    end
    preload_q = 1'b1;
    phase_q   = CAL_IDLE;
    hold_q    = '0;
    ind_q     = 1'b0;
    expected_reports_q.delete();
  endtask

  task automatic apply_write(input logic [1:0] idx, input logic [CfgW-1:0] value);
    case (cfg_idx_e'(idx))
      CFG_THR_DEFAULT: begin
        thr_q[0] = value[ThrW-1:0];
        thr_q[1] = value[ThrW-1:0];
      end
      CFG_THR_MIN:     thr_min_q     = value[ThrW-1:0];
      CFG_THR_MAX:     thr_max_q     = value[ThrW-1:0];
      CFG_STUCK_LIMIT: stuck_limit_q = value;
      default: ;
    endcase
  endtask

  // Half the release-to-press swing, raised to the floor and then cut to the
  // ceiling; a release below the press level goes straight to the ceiling.
  function automatic logic [ThrW-1:0] calibrated_threshold(
    input logic [LevelW-1:0] released,
    input logic [LevelW-1:0] pressed
  );
    int t;
    if (released < pressed) begin
      t = int'(thr_max_q);
    end else begin
      t = (int'(released) - int'(pressed)) / 2;
    end
    if (t < int'(thr_min_q)) begin
      t = int'(thr_min_q);
    end
    if (t > int'(thr_max_q)) begin
      t = int'(thr_max_q);
    end
    return ThrW'(t);
  endfunction

  task automatic predict_scan(input in_item_t scan, output out_item_t report);
    logic [LevelW-1:0] lvl [2];
    logic [MeanW-1:0]  mean;
    logic [1:0]        key;
    logic              abort_now;
    int                k;
    lvl[0]    = scan.level_first;
    lvl[1]    = scan.level_second;
    abort_now = 1'b0;

    for (k = 0; k < 2; k++) begin
      if (preload_q) begin
        base_q[k] = BaseW'(lvl[k]) << AvgShift;
        key[k]    = 1'b0;
      end else begin
        mean   = MeanW'(base_q[k] >> AvgShift);
        // Signed compare: a threshold above the mean never reads as a press.
        key[k] = (int'(mean) - int'(thr_q[k])) > int'(lvl[k]);
        if (!key[k]) begin
          base_q[k] = base_q[k] - BaseW'(mean) + BaseW'(lvl[k]);
        end
      end
    end
    preload_q = 1'b0;

    for (k = 0; k < 2; k++) begin
      if (key[k]) begin
        if (stuck_q[k] != '1) begin
          stuck_q[k] = stuck_q[k] + 1'b1;
        end
        if (stuck_q[k] >= stuck_limit_q) begin
          preload_q = 1'b1;
          abort_now = 1'b1;
        end
      end else begin
        stuck_q[k] = '0;
      end
    end

    case (phase_q)
      CAL_IDLE: begin
        if (&key) phase_q = CAL_CONFIRM;
      end
      CAL_CONFIRM: begin
        if (&key) begin
          press_q[0] = lvl[0];
          press_q[1] = lvl[1];
          hold_q     = '0;
          phase_q    = CAL_TIMING;
        end else begin
          phase_q = CAL_IDLE;
        end
      end
      CAL_TIMING: begin
        ind_q = 1'b1;
        if (&key) begin
          hold_q = hold_q + 1'b1;
          if (hold_q > HoldLimit) begin
            preload_q = 1'b1;
            abort_now = 1'b1;
            phase_q   = CAL_DONE;
          end
        end else if (key == 2'b00) begin
          thr_q[0]  = calibrated_threshold(lvl[0], press_q[0]);
          thr_q[1]  = calibrated_threshold(lvl[1], press_q[1]);
          preload_q = 1'b1;
          phase_q   = CAL_DONE;
        end
      end
      default: begin
        phase_q = CAL_IDLE;
        ind_q   = 1'b0;
      end
    endcase

    report.pressed_first  = key[0];
    report.pressed_second = key[1];
    report.calibrating    = ind_q;
    report.abort_setup    = abort_now;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        apply_write(cfg_idx_i, cfg_wdata_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predict_scan(in_data_i, predicted);
        expected_reports_q.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports_q.size() == 0) begin
          report_mismatch($sformatf("result beat %b with no scan pending", out_data_i));
        end else begin
          oldest = expected_reports_q.pop_front();
          compare_field("pressed_first", out_data_i.pressed_first, oldest.pressed_first);
          compare_field("pressed_second", out_data_i.pressed_second, oldest.pressed_second);
          compare_field("calibrating", out_data_i.calibrating, oldest.calibrating);
          compare_field("abort_setup", out_data_i.abort_setup, oldest.abort_setup);
        end
      end
      outstanding_o <= expected_reports_q.size();
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Capacitive touch detector testbench
// Drives scans through the detector with random gaps and back-pressure under
// several register settings, and lets the result checker judge every beat.
// -----------------------------------------------------------------------------
module tb_top;
  import ctd_pkg::*;

  // Cycles the receiver holds off in one stretch; long enough to fill both
  // the result register and the input register of the block.
  localparam int LongHold      = 64;
  localparam int ItemsPerPhase = 300;
  localparam int LevelMax      = (1 << LevelW) - 1;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [1:0]      cfg_idx;
  logic [CfgW-1:0] cfg_wdata;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_stall;
  out_item_t       out_data;

  int              outstanding;
  int              mismatches;
  int              items_sent = 0;

  // Flags shared between the sender and the receiver processes.
  bit              quiet         = 1'b0;
  bit              long_hold_req = 1'b0;

  // Resting sensor levels that the gestures press down from.
  int              rest [2] = '{700, 700};

  capacitive_touch_detector i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  touch_result_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The whole run is far shorter than this; reaching it means the block hung.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Saturate an arbitrary integer into the range of a sensor reading.
  function automatic logic [LevelW-1:0] to_level(input int v);
    if (v < 0) v = 0;
    if (v > LevelMax) v = LevelMax;
    return LevelW'(v);
  endfunction

  // A reading that sits close to the resting level, as an untouched key does.
  function automatic logic [LevelW-1:0] near(input int r);
    return to_level(r + int'($urandom_range(0, 6)) - 3);
  endfunction

  // A reading well below the resting level, as a finger on the pad gives.
  function automatic logic [LevelW-1:0] pushed(input int r);
    if (r < 100) return '0;
    return to_level(r - int'($urandom_range(100, r)));
  endfunction

  // Offer one scan after a random gap and hold it until the block takes it.
  // The valid stays high across back-to-back beats.
  task automatic send_scan(input logic [LevelW-1:0] first, input logic [LevelW-1:0] second);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{level_first: first, level_second: second};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering scans and wait until every predicted result has come back,
  // then let the two-stage pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write per cycle; the caller lowers the write enable.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [CfgW-1:0] thr_def, thr_min, thr_max, stuck);
    write_reg(CFG_THR_DEFAULT, thr_def);
    write_reg(CFG_THR_MIN, thr_min);
    write_reg(CFG_THR_MAX, thr_max);
    write_reg(CFG_STUCK_LIMIT, stuck);
    cfg_we <= 1'b0;
  endtask

  // Random gestures: resting drift, single taps, full two-key calibration
  // holds, single keys held at times until they count as stuck, raw noise,
  // and moves of the resting levels. Calibration gets the largest share since
  // it is the only way into the deeper states of the block.
  task automatic run_gestures(input int count);
    int stop;
    int kind;
    int len;
    int k;
    stop = items_sent + count;
    while (items_sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        len = $urandom_range(1, 10);
        repeat (len) send_scan(near(rest[0]), near(rest[1]));
      end else if (kind < 40) begin
        k   = $urandom_range(0, 1);
        len = $urandom_range(1, 8);
        repeat (len) begin
          send_scan(k == 0 ? pushed(rest[0]) : near(rest[0]),
                    k == 1 ? pushed(rest[1]) : near(rest[1]));
        end
        send_scan(near(rest[0]), near(rest[1]));
      end else if (kind < 75) begin
        // Both keys down long enough to confirm and time, sometimes past the
        // hold limit, then released one by one or together.
        len = $urandom_range(2, 26);
        repeat (len) send_scan(pushed(rest[0]), pushed(rest[1]));
        if ($urandom_range(0, 1) == 1) begin
          len = $urandom_range(1, 4);
          repeat (len) send_scan(near(rest[0]), pushed(rest[1]));
        end
        if ($urandom_range(0, 3) == 0) begin
          send_scan(to_level(int'($urandom_range(0, LevelMax))), near(rest[1]));
        end else begin
          send_scan(near(rest[0]), near(rest[1]));
        end
        send_scan(near(rest[0]), near(rest[1]));
      end else if (kind < 85) begin
        k   = $urandom_range(0, 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 175) : $urandom_range(1, 40);
        repeat (len) begin
          send_scan(k == 0 ? pushed(rest[0]) : near(rest[0]),
                    k == 1 ? pushed(rest[1]) : near(rest[1]));
        end
      end else if (kind < 95) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          send_scan(to_level(int'($urandom_range(0, LevelMax))),
                    to_level(int'($urandom_range(0, LevelMax))));
        end
      end else begin
        rest[0] = $urandom_range(300, LevelMax);
        rest[1] = $urandom_range(300, LevelMax);
      end
    end
  endtask

  // Receiver: before each result it stalls for a random number of cycles,
  // then takes the next beat. On request it holds off for a long stretch so
  // that the block backs up into its input.
  initial begin : receiver
    int gap;
    out_stall <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_THR_DEFAULT;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings. The first scan preloads the baselines at 800, then both
    // keys are pressed to 600 to confirm and start calibration, one key lets
    // go while the other waits, and a release to 1000 sets both thresholds to
    // half the swing. The scans after that press from the new baseline, fail
    // a confirmation, and hit the level extremes.
    send_scan(10'd800, 10'd800);
    send_scan(10'd600, 10'd600);
    send_scan(10'd600, 10'd600);
    send_scan(10'd600, 10'd600);
    send_scan(10'd600, 10'd800);
    send_scan(10'd1000, 10'd1000);
    send_scan(10'd1000, 10'd1000);
    send_scan(10'd0, 10'd0);
    send_scan(10'd1023, 10'd1023);
    send_scan(10'd1023, 10'd0);
    wait_idle();

    // A threshold above any mean: the difference goes negative and must be
    // compared as a signed number, so nothing reads as pressed.
    load_settings(16'd1023, 16'd1, 16'd1023, 16'd1);
    send_scan(10'd0, 10'd1023);
    send_scan(10'd1023, 10'd0);
    wait_idle();

    // Smallest threshold and stuck limit: any press is stuck at once, which
    // raises the abort flag and forces a preload on the following scan.
    load_settings(16'd1, 16'd1, 16'd1023, 16'd1);
    send_scan(10'd0, 10'd0);
    send_scan(10'd500, 10'd500);
    send_scan(10'd499, 10'd400);
    wait_idle();

    // Crossed clamp limits and a release below the press level. A stuck abort
    // in the timing phase preloads the baselines without leaving calibration,
    // so the preload scan itself is the release, taken at 500 below the press
    // level of 600 on the first key.
    load_settings(16'd100, 16'd500, 16'd300, 16'd3);
    send_scan(10'd800, 10'd800);
    send_scan(10'd600, 10'd600);
    send_scan(10'd600, 10'd600);
    send_scan(10'd600, 10'd600);
    send_scan(10'd500, 10'd1000);
    send_scan(10'd500, 10'd1000);
    wait_idle();

    // Random phases, each under its own settings.
    load_settings(16'(ThrDefaultRst), 16'(ThrMinRst), 16'(ThrMaxRst), StuckLimitRst);
    run_gestures(ItemsPerPhase);
    wait_idle();

    load_settings(16'($urandom_range(30, 300)), 16'($urandom_range(1, 100)),
                  16'($urandom_range(150, LevelMax)), 16'($urandom_range(2, 40)));
    long_hold_req = 1'b1;
    run_gestures(ItemsPerPhase);
    wait_idle();

    // Back-to-back beats on both sides with the widest limits.
    load_settings(16'd1, 16'd1, 16'd1023, 16'd65535);
    quiet = 1'b1;
    run_gestures(ItemsPerPhase);
    quiet = 1'b0;
    wait_idle();

    load_settings(16'd1023, 16'd1023, 16'd1, 16'd1);
    run_gestures(ItemsPerPhase);
    wait_idle();

    load_settings(16'($urandom_range(1, LevelMax)), 16'($urandom_range(1, LevelMax)),
                  16'($urandom_range(1, LevelMax)), 16'($urandom_range(1, 65535)));
    run_gestures(ItemsPerPhase);
    wait_idle();

    load_settings(16'(ThrDefaultRst), 16'(ThrMinRst), 16'(ThrMaxRst), StuckLimitRst);
    long_hold_req = 1'b1;
    run_gestures(ItemsPerPhase);
    wait_idle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
